@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the marker segment tracker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define JMST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled in reset
`define JMST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/jmst_pkg.sv @@
// ----------------------------------------------------------------------------
// jmst_pkg
// Types, codes and marker decode shared by the marker segment tracker.
// ----------------------------------------------------------------------------
package jmst_pkg;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_00  = 8'h00;
    localparam logic [7:0] MRK_SOI  = 8'hD8;
    localparam logic [7:0] MRK_EOI  = 8'hD9;
    localparam logic [7:0] MRK_SOS  = 8'hDA;
    localparam logic [7:0] MRK_SOF0 = 8'hC0;
    localparam logic [7:0] MRK_DHT  = 8'hC4;
    localparam logic [7:0] MRK_DQT  = 8'hDB;
    localparam logic [7:0] MRK_APP0 = 8'hE0;
    localparam logic [7:0] MRK_APP1 = 8'hE1;

    localparam logic [31:0] POS_NONE = 32'hFFFF_FFFF;
    localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFE;

    typedef enum logic [8:0] {
        PH_WANT_FF    = 9'b0_0000_0001,
        PH_TYPE       = 9'b0_0000_0010,
        PH_LEN_HI     = 9'b0_0000_0100,
        PH_LEN_LO     = 9'b0_0000_1000,
        PH_SKIP       = 9'b0_0001_0000,
        PH_ENTROPY    = 9'b0_0010_0000,
        PH_ENTROPY_FF = 9'b0_0100_0000,
        PH_DONE       = 9'b0_1000_0000,
        PH_ERROR      = 9'b1_0000_0000
    } t_phase;

    typedef enum logic [3:0] {
        PC_WANT_FF    = 4'd0,
        PC_TYPE       = 4'd1,
        PC_LEN_HI     = 4'd2,
        PC_LEN_LO     = 4'd3,
        PC_SKIP       = 4'd4,
        PC_ENTROPY    = 4'd5,
        PC_ENTROPY_FF = 4'd6,
        PC_DONE       = 4'd7,
        PC_ERROR      = 4'd8
    } t_phase_code;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_NO_FF   = 3'd1,
        ERR_UNKNOWN = 3'd2,
        ERR_BAD_LEN = 3'd3,
        ERR_FAILED  = 3'd4
    } t_err;

    typedef struct packed {
        logic [3:0]  parse_phase;
        logic        forward_valid;
        logic [7:0]  forward_byte;
        logic [2:0]  error_code;
        logic [7:0]  segment_type;
        logic [31:0] byte_position;
        logic        entropy_pending;
    } t_result;

    function automatic logic [3:0] phase_code(input t_phase ph);
        t_phase_code pc;
        unique case (ph)
            PH_WANT_FF:    pc = PC_WANT_FF;
            PH_TYPE:       pc = PC_TYPE;
            PH_LEN_HI:     pc = PC_LEN_HI;
            PH_LEN_LO:     pc = PC_LEN_LO;
            PH_SKIP:       pc = PC_SKIP;
            PH_ENTROPY:    pc = PC_ENTROPY;
            PH_ENTROPY_FF: pc = PC_ENTROPY_FF;
            PH_DONE:       pc = PC_DONE;
            default:       pc = PC_ERROR;
        endcase
        return pc;
    endfunction

    function automatic t_phase marker_next(input logic [7:0] b);
        t_phase ph;
        unique case (b) inside
            MRK_SOI:                   ph = PH_WANT_FF;
            MRK_EOI:                   ph = PH_DONE;
            MRK_SOS, MRK_SOF0, MRK_DHT,
            MRK_DQT, MRK_APP0, MRK_APP1: ph = PH_LEN_HI;
            default:                   ph = PH_ERROR;
        endcase
        return ph;
    endfunction

    function automatic logic marker_entropy(input logic [7:0] b);
        return (b == MRK_SOS) || (b == MRK_SOF0) || (b == MRK_DHT);
    endfunction

endpackage

@@ design/jmst_in_if.sv @@
// ----------------------------------------------------------------------------
// jmst_in_if
// Input word channel: operation and stream byte.
// ----------------------------------------------------------------------------
interface jmst_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

@@ design/jmst_out_if.sv @@
// ----------------------------------------------------------------------------
// jmst_out_if
// Result word channel of the marker segment tracker.
// ----------------------------------------------------------------------------
interface jmst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  parse_phase;
    logic        forward_valid;
    logic [7:0]  forward_byte;
    logic [2:0]  error_code;
    logic [7:0]  segment_type;
    logic [31:0] byte_position;
    logic        entropy_pending;

    modport source (
        output valid, output parse_phase, output forward_valid, output forward_byte,
        output error_code, output segment_type, output byte_position,
        output entropy_pending, input ready
    );
    modport sink (
        input valid, input parse_phase, input forward_valid, input forward_byte,
        input error_code, input segment_type, input byte_position,
        input entropy_pending, output ready
    );
endinterface

@@ design/jpeg_marker_segment_tracker.sv @@
// An input word is registered, then its result word is registered.
// One word per cycle unless the sink stalls; the parser updates once per word.
// The ready path runs combinationally from the result sink back to the input.
// Reset: synchronous, active low; parser returns to waiting for 0xFF and
// byte position to all ones, both word registers empty.
// ----------------------------------------------------------------------------
// jpeg_marker_segment_tracker
// Follows JPEG marker structure byte by byte and forwards bytes after EOI.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jmst_in_if.sink    i_in,
    jmst_out_if.source o_res
);

    logic              in_valid;
    logic              in_op;
    logic [7:0]        in_byte;
    logic              adv;
    logic              fire;
    jmst_pkg::t_result res;

    assign fire = in_valid && adv;

    jmst_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_op    (in_op),
        .o_byte  (in_byte)
    );

    jmst_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_op    (in_op),
        .i_byte  (in_byte),
        .o_res   (res)
    );

    jmst_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (res),
        .o_adv   (adv),
        .o_res   (o_res)
    );

endmodule

@@ design/jmst_in_reg.sv @@
// ----------------------------------------------------------------------------
// jmst_in_reg
// Input register: one word per cycle unless stalled; holds it for the core.
// ----------------------------------------------------------------------------
module jmst_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jmst_in_if.sink    i_in,
    input  logic       i_adv,
    output logic       o_valid,
    output logic       o_op,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       r_op;
    logic [7:0] r_byte;
    logic       take;

    assign i_in.ready = !r_valid || i_adv;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op   <= i_in.operation;
            r_byte <= i_in.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_byte  = r_byte;

endmodule

@@ design/jmst_core.sv @@
// ----------------------------------------------------------------------------
// jmst_core
// Parser state and single-pass update for one stream byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jmst_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_op,
    input  logic [7:0]        i_byte,
    output jmst_pkg::t_result o_res
);

    jmst_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_pos, n_pos;
    logic [7:0]       r_lh, n_lh;
    logic [15:0]      r_rem, n_rem;
    logic             r_ent, n_ent;
    logic [7:0]       r_mt, n_mt;
    logic             fwd_v;
    jmst_pkg::t_err   err;
    logic [15:0]      len;
    jmst_pkg::t_phase mk_phase;

    assign len      = {r_lh, i_byte};
    assign mk_phase = jmst_pkg::marker_next(i_byte);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_lh    = r_lh;
        n_rem   = r_rem;
        n_ent   = r_ent;
        n_mt    = r_mt;
        fwd_v   = 1'b0;
        err     = jmst_pkg::ERR_NONE;
        if (i_op) begin
            n_phase = jmst_pkg::PH_WANT_FF;
            n_pos   = jmst_pkg::POS_NONE;
            n_lh    = '0;
            n_rem   = '0;
            n_ent   = 1'b0;
            n_mt    = '0;
        end else begin
            if (r_pos == jmst_pkg::POS_NONE) begin
                n_pos = '0;
            end else if (r_pos < jmst_pkg::POS_MAX) begin
                n_pos = r_pos + 32'd1;
            end
            unique case (r_phase)
                jmst_pkg::PH_DONE: begin
                    fwd_v = 1'b1;
                end
                jmst_pkg::PH_WANT_FF: begin
                    if (i_byte != jmst_pkg::BYTE_FF) begin
                        n_phase = jmst_pkg::PH_ERROR;
                        err     = jmst_pkg::ERR_NO_FF;
                    end else begin
                        n_phase = jmst_pkg::PH_TYPE;
                    end
                end
                jmst_pkg::PH_TYPE: begin
                    n_mt    = i_byte;
                    n_phase = mk_phase;
                    if (jmst_pkg::marker_entropy(i_byte)) begin
                        n_ent = 1'b1;
                    end
                    if (mk_phase == jmst_pkg::PH_ERROR) begin
                        err = jmst_pkg::ERR_UNKNOWN;
                    end
                end
                jmst_pkg::PH_LEN_HI: begin
                    n_lh    = i_byte;
                    n_phase = jmst_pkg::PH_LEN_LO;
                end
                jmst_pkg::PH_LEN_LO: begin
                    if (len < 16'd2) begin
                        n_phase = jmst_pkg::PH_ERROR;
                        err     = jmst_pkg::ERR_BAD_LEN;
                    end else if (len == 16'd2) begin
                        n_rem   = '0;
                        n_phase = r_ent ? jmst_pkg::PH_ENTROPY : jmst_pkg::PH_WANT_FF;
                    end else begin
                        n_rem   = len - 16'd2;
                        n_phase = jmst_pkg::PH_SKIP;
                    end
                end
                jmst_pkg::PH_SKIP: begin
                    if (r_rem <= 16'd1) begin
                        n_rem   = '0;
                        n_phase = r_ent ? jmst_pkg::PH_ENTROPY : jmst_pkg::PH_WANT_FF;
                    end else begin
                        n_rem = r_rem - 16'd1;
                    end
                end
                jmst_pkg::PH_ENTROPY: begin
                    if (i_byte == jmst_pkg::BYTE_FF) begin
                        n_phase = jmst_pkg::PH_ENTROPY_FF;
                    end
                end
                jmst_pkg::PH_ENTROPY_FF: begin
                    if (i_byte == jmst_pkg::BYTE_00) begin
                        n_phase = jmst_pkg::PH_ENTROPY;
                    end else if (i_byte != jmst_pkg::BYTE_FF) begin
                        n_mt    = i_byte;
                        n_phase = mk_phase;
                        n_ent   = jmst_pkg::marker_entropy(i_byte);
                        if (mk_phase == jmst_pkg::PH_ERROR) begin
                            err = jmst_pkg::ERR_UNKNOWN;
                        end
                    end
                end
                default: begin
                    n_phase = jmst_pkg::PH_ERROR;
                    err     = jmst_pkg::ERR_FAILED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jmst_pkg::PH_WANT_FF;
            r_pos   <= jmst_pkg::POS_NONE;
            r_lh    <= '0;
            r_rem   <= '0;
            r_ent   <= 1'b0;
            r_mt    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_lh    <= n_lh;
            r_rem   <= n_rem;
            r_ent   <= n_ent;
            r_mt    <= n_mt;
        end
    end

    always_comb begin
        o_res.parse_phase     = jmst_pkg::phase_code(n_phase);
        o_res.forward_valid   = fwd_v;
        o_res.forward_byte    = fwd_v ? i_byte : 8'h00;
        o_res.error_code      = err;
        o_res.segment_type    = n_mt;
        o_res.byte_position   = n_pos;
        o_res.entropy_pending = n_ent;
    end

    `JMST_ASSERT_NXT(a_restart, i_clk, i_rst_n, i_fire && i_op, (r_pos == jmst_pkg::POS_NONE) && (r_phase == jmst_pkg::PH_WANT_FF))
    `JMST_ASSERT_NXT(a_err_sticky, i_clk, i_rst_n, i_fire && !i_op && (r_phase == jmst_pkg::PH_ERROR), r_phase == jmst_pkg::PH_ERROR)
    `JMST_ASSERT_IMP(a_err_phase, i_clk, i_rst_n, o_res.error_code != jmst_pkg::ERR_NONE, o_res.parse_phase == jmst_pkg::PC_ERROR)
    `JMST_ASSERT_NXT(a_hold, i_clk, i_rst_n, !i_fire, $stable(r_phase) && $stable(r_pos) && $stable(r_ent))

endmodule

@@ design/jmst_out_reg.sv @@
// ----------------------------------------------------------------------------
// jmst_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module jmst_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jmst_pkg::t_result i_res,
    output logic              o_adv,
    jmst_out_if.source        o_res
);

    logic              r_valid;
    jmst_pkg::t_result r_res;

    assign o_adv = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.parse_phase     = r_res.parse_phase;
    assign o_res.forward_valid   = r_res.forward_valid;
    assign o_res.forward_byte    = r_res.forward_byte;
    assign o_res.error_code      = r_res.error_code;
    assign o_res.segment_type    = r_res.segment_type;
    assign o_res.byte_position   = r_res.byte_position;
    assign o_res.entropy_pending = r_res.entropy_pending;

endmodule

@@ tb/jmst_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmst_tb_pkg
// Operation codes of the input word, shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package jmst_tb_pkg;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

endpackage

@@ tb/jmst_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmst_result_checker
// Watches the input and result channels of the marker segment tracker. Every
// accepted input word runs through a behavioral copy of the parser, and the
// expected result words wait in order until the block delivers them; each
// delivered word is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module jmst_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    jmst_in_if   i_in_mon,
    jmst_out_if  i_res_mon,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked,
    output int   o_forwarded,
    output int   o_flagged
);
    import jmst_pkg::*;
    import jmst_tb_pkg::*;

    t_phase_code trk_phase;
    logic [31:0] trk_position;
    logic [7:0]  trk_len_hi;
    logic [15:0] trk_remaining;
    logic        trk_entropy;
    logic [7:0]  trk_marker;

    t_result expected_results[$];

    function automatic void clear_tracker();
        trk_phase     = PC_WANT_FF;
        trk_position  = POS_NONE;
        trk_len_hi    = '0;
        trk_remaining = '0;
        trk_entropy   = 1'b0;
        trk_marker    = '0;
    endfunction

    function automatic t_err accept_marker(input logic [7:0] b);
        trk_marker = b;
        case (b)
            MRK_SOI: trk_phase = PC_WANT_FF;
            MRK_EOI: trk_phase = PC_DONE;
            MRK_SOS, MRK_SOF0, MRK_DHT: begin
                trk_entropy = 1'b1;
                trk_phase   = PC_LEN_HI;
            end
            MRK_DQT, MRK_APP0, MRK_APP1: trk_phase = PC_LEN_HI;
            default: begin
                trk_phase = PC_ERROR;
                return ERR_UNKNOWN;
            end
        endcase
        return ERR_NONE;
    endfunction

    function automatic t_result track_word(input t_op op, input logic [7:0] b);
        t_result     r;
        t_err        err;
        logic [15:0] seg_len;
        r   = '0;
        err = ERR_NONE;
        if (op == OP_RESTART) begin
            clear_tracker();
        end else begin
            if (trk_position == POS_NONE) begin
                trk_position = '0;
            end else if (trk_position < POS_MAX) begin
                trk_position = trk_position + 32'd1;
            end
            case (trk_phase)
                PC_DONE: begin
                    r.forward_valid = 1'b1;
                    r.forward_byte  = b;
                end
                PC_WANT_FF: begin
                    if (b != BYTE_FF) begin
                        trk_phase = PC_ERROR;
                        err       = ERR_NO_FF;
                    end else begin
                        trk_phase = PC_TYPE;
                    end
                end
                PC_TYPE: err = accept_marker(b);
                PC_LEN_HI: begin
                    trk_len_hi = b;
                    trk_phase  = PC_LEN_LO;
                end
                PC_LEN_LO: begin
                    seg_len = {trk_len_hi, b};
                    if (seg_len < 16'd2) begin
                        trk_phase = PC_ERROR;
                        err       = ERR_BAD_LEN;
                    end else if (seg_len == 16'd2) begin
                        trk_remaining = '0;
                        trk_phase     = trk_entropy ? PC_ENTROPY : PC_WANT_FF;
                    end else begin
                        trk_remaining = seg_len - 16'd2;
                        trk_phase     = PC_SKIP;
                    end
                end
                PC_SKIP: begin
                    if (trk_remaining <= 16'd1) begin
                        trk_remaining = '0;
                        trk_phase     = trk_entropy ? PC_ENTROPY : PC_WANT_FF;
                    end else begin
                        trk_remaining = trk_remaining - 16'd1;
                    end
                end
                PC_ENTROPY: begin
                    if (b == BYTE_FF) trk_phase = PC_ENTROPY_FF;
                end
                PC_ENTROPY_FF: begin
                    if (b == BYTE_00) begin
                        trk_phase = PC_ENTROPY;
                    end else if (b != BYTE_FF) begin
                        trk_entropy = 1'b0;
                        err         = accept_marker(b);
                    end
                end
                default: begin
                    trk_phase = PC_ERROR;
                    err       = ERR_FAILED;
                end
            endcase
        end
        r.parse_phase     = trk_phase;
        r.error_code      = err;
        r.segment_type    = trk_marker;
        r.byte_position   = trk_position;
        r.entropy_pending = trk_entropy;
        return r;
    endfunction

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        o_checked     = 0;
        o_forwarded   = 0;
        o_flagged     = 0;
    end

    always @(posedge i_clk) begin
        t_result got_word;
        t_result want_word;
        if (!i_rst_n) begin
            clear_tracker();
            expected_results.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_results.push_back(
                    track_word(t_op'(i_in_mon.operation), i_in_mon.data_byte));
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                got_word.parse_phase     = i_res_mon.parse_phase;
                got_word.forward_valid   = i_res_mon.forward_valid;
                got_word.forward_byte    = i_res_mon.forward_byte;
                got_word.error_code      = i_res_mon.error_code;
                got_word.segment_type    = i_res_mon.segment_type;
                got_word.byte_position   = i_res_mon.byte_position;
                got_word.entropy_pending = i_res_mon.entropy_pending;
                o_checked++;
                if (got_word.forward_valid === 1'b1) o_forwarded++;
                if (got_word.error_code !== ERR_NONE) o_flagged++;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: result word with nothing expected: phase=%0d err=%0d pos=%08h",
                                 $time, got_word.parse_phase, got_word.error_code,
                                 got_word.byte_position);
                    end
                end else begin
                    want_word = expected_results.pop_front();
                    if (got_word.parse_phase     !== want_word.parse_phase     ||
                        got_word.forward_valid   !== want_word.forward_valid   ||
                        got_word.forward_byte    !== want_word.forward_byte    ||
                        got_word.error_code      !== want_word.error_code      ||
                        got_word.segment_type    !== want_word.segment_type    ||
                        got_word.byte_position   !== want_word.byte_position   ||
                        got_word.entropy_pending !== want_word.entropy_pending) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: expected phase=%0d fwd=%0b/%02h err=%0d seg=%02h pos=%08h ent=%0b",
                                     $time, want_word.parse_phase, want_word.forward_valid,
                                     want_word.forward_byte, want_word.error_code,
                                     want_word.segment_type, want_word.byte_position,
                                     want_word.entropy_pending);
                            $display("%0t: actual   phase=%0d fwd=%0b/%02h err=%0d seg=%02h pos=%08h ent=%0b",
                                     $time, got_word.parse_phase, got_word.forward_valid,
                                     got_word.forward_byte, got_word.error_code,
                                     got_word.segment_type, got_word.byte_position,
                                     got_word.entropy_pending);
                        end
                    end
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

@@ tb/tb_jpeg_marker_segment_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jpeg_marker_segment_tracker
// Drives JPEG-like byte streams into the marker segment tracker: a directed
// opening over errors, stuffing, fill and end of image, then random images
// built from known segments and entropy runs mixed with noise and restarts.
// Both channels idle in random bursts; the checker judges every result word.
// ----------------------------------------------------------------------------
module tb_jpeg_marker_segment_tracker;
    import jmst_pkg::*;
    import jmst_tb_pkg::*;

    localparam int N_WORDS          = 950;
    localparam int QUIET_WORDS      = 120;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES     = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int  fail_count;
    int  outstanding;
    int  checked;
    int  forwarded;
    int  flagged;
    int  words_sent = 0;
    bit  quiet = 1'b0;
    bit  long_hold_req = 1'b0;

    logic [7:0] seg_markers [6] = '{MRK_SOS, MRK_SOF0, MRK_DHT, MRK_DQT, MRK_APP0, MRK_APP1};

    jmst_in_if  in_ch ();
    jmst_out_if res_ch ();

    jpeg_marker_segment_tracker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    jmst_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_res_mon     (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_forwarded   (forwarded),
        .o_flagged     (flagged)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // enter and leave at a falling edge
    task automatic send_word(input t_op op, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_entropy_run(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = $urandom_range(0, 4) == 0 ? BYTE_FF : 8'($urandom);
            send_word(OP_BYTE, b);
            if (b == BYTE_FF) begin
                if ($urandom_range(0, 3) == 0) send_word(OP_BYTE, BYTE_FF);
                send_word(OP_BYTE, BYTE_00);
            end
        end
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int          n_segs;
        int          idx;
        logic [15:0] seg_len;
        logic [7:0]  typ;
        bit          in_entropy;
        bit          broken;
        bit          hold_done;
        bit          pause_done;

        hold_done       = 1'b0;
        pause_done      = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_BYTE;
        in_ch.data_byte = '0;
        res_ch.ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // missing FF, then a byte in the failed state
        send_word(OP_RESTART, BYTE_FF);
        send_word(OP_BYTE, BYTE_00);
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_RESTART, BYTE_00);
        // SOI, SOF0 of length two, stuffing, fill, DHT found in entropy data
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, MRK_SOI);
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, MRK_SOF0);
        send_word(OP_BYTE, BYTE_00);
        send_word(OP_BYTE, 8'h02);
        send_word(OP_BYTE, 8'h12);
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, BYTE_00);
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, MRK_DHT);
        send_word(OP_BYTE, BYTE_00);
        send_word(OP_BYTE, 8'h03);
        send_word(OP_BYTE, 8'h77);
        // restart marker inside entropy data is unknown
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, 8'hD0);
        send_word(OP_RESTART, 8'h80);
        // length below two
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, MRK_DQT);
        send_word(OP_BYTE, BYTE_00);
        send_word(OP_BYTE, 8'h01);
        send_word(OP_RESTART, 8'h7F);
        // end of image, then forward
        send_word(OP_BYTE, BYTE_FF);
        send_word(OP_BYTE, MRK_EOI);
        send_word(OP_BYTE, BYTE_FF);

        while (words_sent < N_WORDS) begin
            if (!hold_done && words_sent > 300) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            if (!pause_done && words_sent > 600) begin
                in_ch.valid <= 1'b0;
                wait (outstanding == 0);
                @(negedge i_clk);
                pause_done = 1'b1;
            end
            if (words_sent > N_WORDS - QUIET_WORDS) quiet = 1'b1;

            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_word($urandom_range(0, 7) == 0 ? OP_RESTART : OP_BYTE, 8'($urandom));
                end
            end else begin
                if ($urandom_range(0, 3) != 0) send_word(OP_RESTART, 8'($urandom));
                send_word(OP_BYTE, BYTE_FF);
                send_word(OP_BYTE, MRK_SOI);
                in_entropy = 1'b0;
                broken     = 1'b0;
                n_segs     = $urandom_range(1, 4);
                for (int s = 0; s < n_segs && !broken; s++) begin
                    if (in_entropy) send_entropy_run($urandom_range(0, 10));
                    idx = $urandom_range(0, 19);
                    if (idx == 0) begin
                        typ = in_entropy ? 8'(8'hD0 + $urandom_range(0, 7))
                                         : 8'($urandom_range(8'h01, 8'hBF));
                    end else if (idx == 1) begin
                        typ = MRK_SOI;
                    end else begin
                        idx = $urandom_range(0, 5);
                        typ = seg_markers[idx];
                    end
                    send_word(OP_BYTE, BYTE_FF);
                    send_word(OP_BYTE, typ);
                    if (typ == MRK_SOI) begin
                        in_entropy = 1'b0;
                    end else if (typ inside {MRK_SOS, MRK_SOF0, MRK_DHT,
                                             MRK_DQT, MRK_APP0, MRK_APP1}) begin
                        idx = $urandom_range(0, 199);
                        if (idx < 4) begin
                            seg_len = 16'($urandom_range(0, 1));
                        end else if (idx == 4) begin
                            seg_len = 16'(16'h0100 + $urandom_range(0, 4));
                        end else begin
                            seg_len = 16'($urandom_range(2, 10));
                        end
                        send_word(OP_BYTE, seg_len[15:8]);
                        send_word(OP_BYTE, seg_len[7:0]);
                        if (seg_len < 16'd2) begin
                            broken = 1'b1;
                        end else begin
                            repeat (int'(seg_len) - 2) send_word(OP_BYTE, 8'($urandom));
                            in_entropy = typ inside {MRK_SOS, MRK_SOF0, MRK_DHT};
                        end
                    end else begin
                        broken = 1'b1;
                    end
                end
                if (broken) begin
                    repeat ($urandom_range(1, 3)) send_word(OP_BYTE, 8'($urandom));
                end else begin
                    if (in_entropy) send_entropy_run($urandom_range(0, 10));
                    if ($urandom_range(0, 9) != 0) begin
                        send_word(OP_BYTE, BYTE_FF);
                        send_word(OP_BYTE, MRK_EOI);
                        repeat ($urandom_range(0, 5)) send_word(OP_BYTE, 8'($urandom));
                    end
                end
            end
        end
        in_ch.valid <= 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d words; checked %0d result words.", words_sent, checked);
        $display("Results: %0d bytes forwarded after EOI, %0d words with a parse error code.",
                 forwarded, flagged);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
